>>> rtl/rpvc_pkg.sv
package rpvc_pkg;

  // Form codes carried on the input channel.
  localparam logic [1:0] FORM_RECT  = 2'd0;
  localparam logic [1:0] FORM_POLAR = 2'd1;

  // Datapath widths.
  localparam int unsigned CW  = 32;  // CORDIC x and y, Q20
  localparam int unsigned ZW  = 34;  // CORDIC angle, Q30 radians
  localparam int unsigned ZPW = 35;  // polar angle before range reduction
  localparam int unsigned RW  = 36;  // radicand, remainder and root of the square root

  // The square root resolves one result bit per stage.
  localparam int unsigned SQRT_STEPS = 18;

  // Angle constants in Q30 radians.
  localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [ZW-1:0] TWO_PI_Q30  = 34'sd6746518852;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;

  // Inverse CORDIC gain in Q30.
  localparam logic signed [30:0] INV_GAIN_Q30 = 31'sd652032874;

  // Degrees to radians, pi/180 in Q40, split at bit 17 for two narrow products.
  localparam logic [35:0]        DEG2RAD_Q40 = 36'd19190098064;
  localparam logic signed [18:0] DEG_HI      = 19'(DEG2RAD_Q40 >> 17);
  localparam logic signed [17:0] DEG_LO      = 18'(DEG2RAD_Q40 & 36'h1FFFF);

  // Limits of a Q10.8 coordinate.
  localparam logic signed [17:0] Q8_MAX = 18'sh1FFFF;
  localparam logic signed [17:0] Q8_MIN = 18'sh20000;

  // Arctangent of 2^-i in Q30 for the first ten steps.
  localparam logic [29:0] ATAN_LOW [10] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516,  30'd16775851,  30'd8388437,   30'd4194283,   30'd2097149
  };

  // Work item that travels through the rotation and root stages.
  typedef struct packed {
    logic                   polar;
    logic                   bad;
    logic                   zero;
    logic                   flip;
    logic signed [17:0]     coord_a;
    logic signed [17:0]     coord_b;
    logic signed [17:0]     pang;
    logic signed [CW-1:0]   cx;
    logic signed [CW-1:0]   cy;
    logic signed [ZW-1:0]   z;
    logic [RW-1:0]          rem;
    logic [RW-1:0]          root;
  } rpvc_core_t;

  // Arctangent of 2^-i; beyond the table it equals 2^-i itself.
  function automatic logic signed [ZW-1:0] atan_q30(input int unsigned i);
    logic [3:0] idx;
    idx = i[3:0];
    if (i < 10) begin
      atan_q30 = ZW'(ATAN_LOW[idx]);
    end else if (i < 31) begin
      atan_q30 = ZW'(1) <<< (30 - i);
    end else begin
      atan_q30 = '0;
    end
  endfunction

  // Clamp a value to the Q10.8 coordinate range.
  function automatic logic signed [17:0] sat18(input logic signed [20:0] v);
    if (v > 21'(Q8_MAX)) begin
      sat18 = Q8_MAX;
    end else if (v < 21'(Q8_MIN)) begin
      sat18 = Q8_MIN;
    end else begin
      sat18 = v[17:0];
    end
  endfunction

endpackage

>>> rtl/rpvc_if.sv
// Input channel: coordinates and form code.
interface rpvc_in_if;
  import rpvc_pkg::*;

  logic               valid;
  logic               ready;
  logic signed [17:0] first_coord;
  logic signed [17:0] second_coord;
  logic [1:0]         form_code;

  modport source (output valid, first_coord, second_coord, form_code, input ready);
  modport sink   (input valid, first_coord, second_coord, form_code, output ready);
endinterface

// Result channel: full vector description.
interface rpvc_out_if;
  import rpvc_pkg::*;

  logic               valid;
  logic               ready;
  logic signed [17:0] out_x;
  logic signed [17:0] out_y;
  logic signed [18:0] out_magnitude;
  logic signed [17:0] out_angle;
  logic               out_mode;
  logic               bad_form;

  modport source (output valid, out_x, out_y, out_magnitude, out_angle, out_mode, bad_form,
                  input ready);
  modport sink   (input valid, out_x, out_y, out_magnitude, out_angle, out_mode, bad_form,
                  output ready);
endinterface

>>> rtl/rect_polar_vector_converter.sv
// Channel  Direction  Handshake            Beat contents
// in_ch    input      valid/ready          first_coord, second_coord, form_code
// out_ch   output     valid/ready          out_x, out_y, out_magnitude, out_angle,
//                                          out_mode, bad_form
//
// One beat is accepted per clock unless a stall on out_ch has filled every stage.
// The pipeline is four setup stages, one stage per CORDIC micro-rotation and square
// root digit (the longer of the two chains sets the depth), and the output register.
// Reset is synchronous and active low; it clears only the valid bits.
// Every stage holds its beat while the next one is full, and empty stages fill
// up, so input beats keep flowing while a result waits on out_ch until all are full.
module rect_polar_vector_converter #(
  parameter int unsigned ROTATION_STEPS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  rpvc_in_if.sink    in_ch,
  rpvc_out_if.source out_ch
);
  import rpvc_pkg::*;

  localparam int unsigned NCORE = (ROTATION_STEPS > SQRT_STEPS) ? ROTATION_STEPS : SQRT_STEPS;

  logic       vld [NCORE+1];
  logic       rdy [NCORE+1];
  rpvc_core_t dat [NCORE+1];

  // Products, angle conversion and range reduction.
  rpvc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .dn_vld  (vld[0]),
    .dn_rdy  (rdy[0]),
    .dn_data (dat[0])
  );

  // Chain of rotation and root stages.
  for (genvar k = 0; k < NCORE; k++) begin : g_step
    rpvc_step #(
      .IDX            (k),
      .ROTATION_STEPS (ROTATION_STEPS)
    ) u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .up_vld  (vld[k]),
      .up_rdy  (rdy[k]),
      .up_data (dat[k]),
      .dn_vld  (vld[k+1]),
      .dn_rdy  (rdy[k+1]),
      .dn_data (dat[k+1])
    );
  end

  // Rounding, saturation and the output register.
  rpvc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_vld  (vld[NCORE]),
    .up_rdy  (rdy[NCORE]),
    .up_data (dat[NCORE]),
    .out_ch  (out_ch)
  );

endmodule

>>> rtl/rpvc_front.sv
module rpvc_front (
  input  logic                 clk,
  input  logic                 rst_n,
  rpvc_in_if.sink              in_ch,
  output logic                 dn_vld,
  input  logic                 dn_rdy,
  output rpvc_pkg::rpvc_core_t dn_data
);
  import rpvc_pkg::*;

  typedef struct packed {
    logic               polar;
    logic               bad;
    logic signed [17:0] a;
    logic signed [17:0] b;
    logic [34:0]        sq_a;
    logic [34:0]        sq_b;
    logic signed [47:0] gain;
    logic signed [36:0] p_hi;
    logic signed [35:0] p_lo;
  } f1_t;

  typedef struct packed {
    logic                  polar;
    logic                  bad;
    logic                  zero;
    logic signed [17:0]    a;
    logic signed [17:0]    b;
    logic [RW-1:0]         rad;
    logic signed [CW-1:0]  cx;
    logic signed [CW-1:0]  cy;
    logic signed [ZPW-1:0] z;
  } f2_t;

  typedef struct packed {
    logic                 polar;
    logic                 bad;
    logic                 zero;
    logic signed [17:0]   a;
    logic signed [17:0]   b;
    logic [RW-1:0]        rad;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [ZW-1:0] z;
    logic signed [17:0]   pang;
  } f3_t;

  f1_t        s1_r, s1_nxt;
  f2_t        s2_r, s2_nxt;
  f3_t        s3_r, s3_nxt;
  rpvc_core_t s4_r, s4_nxt;
  logic       vld1_r, vld2_r, vld3_r, vld4_r;
  logic       rdy1, rdy2, rdy3, rdy4;

  logic signed [35:0]     sq_a_full, sq_b_full;
  logic signed [53:0]     zsum;
  logic signed [47:0]     gsum;
  logic signed [CW-1:0]   acx, bcy;
  logic signed [35:0]     psum;
  logic signed [18:0]     pa;
  logic signed [ZPW-1:0]  zred;

  // A stage takes a new beat when it is empty or its successor moves on.
  assign rdy4        = !vld4_r || dn_rdy;
  assign rdy3        = !vld3_r || rdy4;
  assign rdy2        = !vld2_r || rdy3;
  assign rdy1        = !vld1_r || rdy2;
  assign in_ch.ready = rdy1;
  assign dn_vld      = vld4_r;
  assign dn_data     = s4_r;

  // Stage 1: all products of the item.
  assign sq_a_full = 36'(in_ch.first_coord) * 36'(in_ch.first_coord);
  assign sq_b_full = 36'(in_ch.second_coord) * 36'(in_ch.second_coord);

  always_comb begin
    s1_nxt.polar = (in_ch.form_code == FORM_POLAR);
    s1_nxt.bad   = (in_ch.form_code != FORM_RECT) && (in_ch.form_code != FORM_POLAR);
    s1_nxt.a     = in_ch.first_coord;
    s1_nxt.b     = in_ch.second_coord;
    s1_nxt.sq_a  = sq_a_full[34:0];
    s1_nxt.sq_b  = sq_b_full[34:0];
    s1_nxt.gain  = 48'(in_ch.first_coord) * 48'(INV_GAIN_Q30);
    s1_nxt.p_hi  = 37'(in_ch.second_coord) * 37'(DEG_HI);
    s1_nxt.p_lo  = 36'(in_ch.second_coord) * 36'(DEG_LO);
  end

  // Stage 2: radicand, polar angle in Q30, and the starting vector.
  assign zsum = (54'(s1_r.p_hi) <<< 17) + 54'(s1_r.p_lo) + (54'sd1 <<< 17);
  assign gsum = s1_r.gain + (48'sd1 <<< 17);
  assign acx  = 32'(s1_r.a) <<< 12;
  assign bcy  = 32'(s1_r.b) <<< 12;

  always_comb begin
    s2_nxt.polar = s1_r.polar;
    s2_nxt.bad   = s1_r.bad;
    s2_nxt.zero  = (s1_r.a == '0) && (s1_r.b == '0);
    s2_nxt.a     = s1_r.a;
    s2_nxt.b     = s1_r.b;
    s2_nxt.rad   = RW'(s1_r.sq_a) + RW'(s1_r.sq_b);
    if (s1_r.polar) begin
      s2_nxt.cx = CW'($signed(gsum[47:18]));
      s2_nxt.cy = '0;
      s2_nxt.z  = $signed(zsum[ZPW+17:18]);
    end else if (s1_r.a[17]) begin
      // Left half plane: turn the vector by pi first.
      s2_nxt.cx = -acx;
      s2_nxt.cy = -bcy;
      s2_nxt.z  = s1_r.b[17] ? -ZPW'(PI_Q30) : ZPW'(PI_Q30);
    end else begin
      s2_nxt.cx = acx;
      s2_nxt.cy = bcy;
      s2_nxt.z  = '0;
    end
  end

  // Stage 3: polar output angle and reduction into the range from -pi to pi.
  assign psum = 36'(s2_r.z) + (36'sd1 <<< 16);
  assign pa   = $signed(psum[35:17]);

  always_comb begin
    if (s2_r.polar && (s2_r.z > ZPW'(PI_Q30))) begin
      zred = s2_r.z - ZPW'(TWO_PI_Q30);
    end else if (s2_r.polar && (s2_r.z < -ZPW'(PI_Q30))) begin
      zred = s2_r.z + ZPW'(TWO_PI_Q30);
    end else begin
      zred = s2_r.z;
    end
    s3_nxt.polar = s2_r.polar;
    s3_nxt.bad   = s2_r.bad;
    s3_nxt.zero  = s2_r.zero;
    s3_nxt.a     = s2_r.a;
    s3_nxt.b     = s2_r.b;
    s3_nxt.rad   = s2_r.rad;
    s3_nxt.cx    = s2_r.cx;
    s3_nxt.cy    = s2_r.cy;
    s3_nxt.z     = ZW'(zred);
    s3_nxt.pang  = sat18(21'(pa));
  end

  // Stage 4: fold the polar angle into the range from -pi/2 to pi/2.
  always_comb begin
    s4_nxt.polar   = s3_r.polar;
    s4_nxt.bad     = s3_r.bad;
    s4_nxt.zero    = s3_r.zero;
    s4_nxt.coord_a = s3_r.a;
    s4_nxt.coord_b = s3_r.b;
    s4_nxt.pang    = s3_r.pang;
    s4_nxt.cx      = s3_r.cx;
    s4_nxt.cy      = s3_r.cy;
    s4_nxt.rem     = s3_r.rad;
    s4_nxt.root    = '0;
    if (s3_r.polar && (s3_r.z > HALF_PI_Q30)) begin
      s4_nxt.z    = s3_r.z - PI_Q30;
      s4_nxt.flip = 1'b1;
    end else if (s3_r.polar && (s3_r.z < -HALF_PI_Q30)) begin
      s4_nxt.z    = s3_r.z + PI_Q30;
      s4_nxt.flip = 1'b1;
    end else begin
      s4_nxt.z    = s3_r.z;
      s4_nxt.flip = 1'b0;
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else begin
      if (rdy1) vld1_r <= in_ch.valid;
      if (rdy2) vld2_r <= vld1_r;
      if (rdy3) vld3_r <= vld2_r;
      if (rdy4) vld4_r <= vld3_r;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (rdy1) s1_r <= s1_nxt;
    if (rdy2) s2_r <= s2_nxt;
    if (rdy3) s3_r <= s3_nxt;
    if (rdy4) s4_r <= s4_nxt;
  end

endmodule

>>> rtl/rpvc_step.sv
module rpvc_step #(
  parameter int unsigned IDX            = 0,
  parameter int unsigned ROTATION_STEPS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_vld,
  output logic                 up_rdy,
  input  rpvc_pkg::rpvc_core_t up_data,
  output logic                 dn_vld,
  input  logic                 dn_rdy,
  output rpvc_pkg::rpvc_core_t dn_data
);
  import rpvc_pkg::*;

  localparam bit              DO_ROT   = (IDX < ROTATION_STEPS);
  localparam bit              DO_SQRT  = (IDX < SQRT_STEPS);
  localparam int unsigned     SQ_SHIFT = DO_SQRT ? 2 * (SQRT_STEPS - 1 - IDX) : 0;
  localparam logic [RW:0]     SQ_BIT   = (RW + 1)'(1) << SQ_SHIFT;
  localparam logic signed [ZW-1:0] ATAN_I = atan_q30(IDX);

  rpvc_core_t           data_r, data_nxt;
  logic                 vld_r;
  logic signed [CW-1:0] dx, dy;
  logic                 rot;
  logic [RW:0]          trial;

  assign up_rdy  = !vld_r || dn_rdy;
  assign dn_vld  = vld_r;
  assign dn_data = data_r;

  // Vectoring drives y to zero, rotation drives the residual angle to zero.
  assign dx    = up_data.cy >>> IDX;
  assign dy    = up_data.cx >>> IDX;
  assign rot   = up_data.polar ? !up_data.z[ZW-1] : up_data.cy[CW-1];
  assign trial = {1'b0, up_data.root} + SQ_BIT;

  always_comb begin
    data_nxt = up_data;
    // One CORDIC micro-rotation.
    if (DO_ROT) begin
      if (rot) begin
        data_nxt.cx = up_data.cx - dx;
        data_nxt.cy = up_data.cy + dy;
        data_nxt.z  = up_data.z - ATAN_I;
      end else begin
        data_nxt.cx = up_data.cx + dx;
        data_nxt.cy = up_data.cy - dy;
        data_nxt.z  = up_data.z + ATAN_I;
      end
    end
    // One digit of the restoring square root.
    if (DO_SQRT) begin
      if ({1'b0, up_data.rem} >= trial) begin
        data_nxt.rem  = up_data.rem - RW'(trial);
        data_nxt.root = (up_data.root >> 1) + RW'(SQ_BIT);
      end else begin
        data_nxt.root = up_data.root >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_rdy) begin
      vld_r <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy) data_r <= data_nxt;
  end

endmodule

>>> rtl/rpvc_back.sv
module rpvc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_vld,
  output logic                 up_rdy,
  input  rpvc_pkg::rpvc_core_t up_data,
  rpvc_out_if.source           out_ch
);
  import rpvc_pkg::*;

  logic               vld_r;
  logic signed [17:0] x_r, y_r, ang_r;
  logic signed [18:0] mag_r;
  logic               mode_r, bad_r;
  logic signed [17:0] x_nxt, y_nxt, ang_nxt;
  logic signed [18:0] mag_nxt;
  logic               mode_nxt, bad_nxt;

  logic signed [32:0] vx, vy;
  logic signed [34:0] asum;
  logic signed [18:0] root_mag;

  // The output register takes a beat whenever it is empty or being drained.
  assign up_rdy = !vld_r || out_ch.ready;

  // Polar coordinates: undo the fold, round Q20 to Q10.8.
  assign vx = up_data.flip ? (33'sd2048 - 33'(up_data.cx)) : (33'(up_data.cx) + 33'sd2048);
  assign vy = up_data.flip ? (33'sd2048 - 33'(up_data.cy)) : (33'(up_data.cy) + 33'sd2048);

  // Rectangular angle rounded to Q5.13, and the root rounded to nearest.
  assign asum     = 35'(up_data.z) + (35'sd1 <<< 16);
  assign root_mag = 19'(up_data.root[17:0]) + 19'(up_data.rem > up_data.root);

  always_comb begin
    if (up_data.bad) begin
      x_nxt    = '0;
      y_nxt    = '0;
      mag_nxt  = '0;
      ang_nxt  = '0;
      mode_nxt = 1'b0;
      bad_nxt  = 1'b1;
    end else if (up_data.polar) begin
      x_nxt    = sat18($signed(vx[32:12]));
      y_nxt    = sat18($signed(vy[32:12]));
      mag_nxt  = 19'(up_data.coord_a);
      ang_nxt  = up_data.pang;
      mode_nxt = 1'b1;
      bad_nxt  = 1'b0;
    end else begin
      x_nxt    = up_data.coord_a;
      y_nxt    = up_data.coord_b;
      mag_nxt  = root_mag;
      ang_nxt  = up_data.zero ? '0 : $signed(asum[34:17]);
      mode_nxt = 1'b0;
      bad_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_rdy) begin
      vld_r <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      mag_r  <= mag_nxt;
      ang_r  <= ang_nxt;
      mode_r <= mode_nxt;
      bad_r  <= bad_nxt;
    end
  end

  assign out_ch.valid         = vld_r;
  assign out_ch.out_x         = x_r;
  assign out_ch.out_y         = y_r;
  assign out_ch.out_magnitude = mag_r;
  assign out_ch.out_angle     = ang_r;
  assign out_ch.out_mode      = mode_r;
  assign out_ch.bad_form      = bad_r;

endmodule
